/* src/tkst_pkg.sv */
// Shared types and constants of the top-k score table.
`default_nettype none

package tkst_pkg;

  localparam int RANK_SIZE = 16;
  localparam int IDX_W     = $clog2(RANK_SIZE);
  localparam int CNT_W     = $clog2(RANK_SIZE + 1);
  localparam int ID_W      = 31;
  localparam int SCORE_W   = 32;

  localparam logic [1:0] OP_UPDATE = 2'd0;
  localparam logic [1:0] OP_READ   = 2'd1;
  localparam logic [1:0] OP_CLEAR  = 2'd2;

  typedef struct packed {
    logic [1:0]                operation;
    logic [ID_W-1:0]           player_id;
    logic signed [SCORE_W-1:0] total_score;
    logic signed [SCORE_W-1:0] score_delta;
    logic [IDX_W-1:0]          read_index;
  } item_t;

  typedef struct packed {
    logic                      ranked;
    logic [IDX_W-1:0]          rank_position;
    logic [ID_W-1:0]           entry_id;
    logic signed [SCORE_W-1:0] entry_score;
    logic [CNT_W-1:0]          entry_count;
  } result_t;

  typedef struct packed {
    logic [ID_W-1:0]           id;
    logic signed [SCORE_W-1:0] score;
  } entry_t;

  typedef struct packed {
    logic start;
    logic take;
  } eng_ctl_t;

  typedef struct packed {
    logic idle;
    logic done;
  } eng_sts_t;

endpackage

`default_nettype wire

/* src/tkst_engine.sv */
// Table memory and the scan, decide and shift sequencer of the score table.
`default_nettype none

module tkst_engine import tkst_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  eng_ctl_t ctl,
  input  item_t    cmd_in,
  output eng_sts_t sts,
  output result_t  res
);

  localparam int ST_W = 3;
  localparam logic [ST_W-1:0] S_IDLE   = 3'd0;
  localparam logic [ST_W-1:0] S_SCAN   = 3'd1;
  localparam logic [ST_W-1:0] S_DECIDE = 3'd2;
  localparam logic [ST_W-1:0] S_MOVE   = 3'd3;
  localparam logic [ST_W-1:0] S_WRITE  = 3'd4;
  localparam logic [ST_W-1:0] S_READ   = 3'd5;
  localparam logic [ST_W-1:0] S_DONE   = 3'd6;

  logic [ST_W-1:0]           state;
  item_t                     cmd;
  logic [CNT_W-1:0]          count;
  logic [CNT_W-1:0]          scan_addr;
  logic                      pend;
  logic [IDX_W-1:0]          pend_idx;
  logic                      found;
  logic [IDX_W-1:0]          fidx;
  logic signed [SCORE_W-1:0] fscore;
  logic signed [SCORE_W-1:0] lscore;
  logic [CNT_W-1:0]          pos;
  logic [IDX_W-1:0]          dst;
  logic [IDX_W-1:0]          mv_addr;
  logic [CNT_W-1:0]          mv_left;
  logic                      mv_up;
  result_t                   res_r;

  entry_t           mem [RANK_SIZE];
  logic             rd_en;
  logic [IDX_W-1:0] rd_addr;
  entry_t           rd_data;
  logic             wr_en;
  logic [IDX_W-1:0] wr_addr;
  entry_t           wr_data;

  logic             scan_go;
  logic             mv_go;
  logic             s_match;
  logic             s_gt;
  logic             s_eq;
  logic [IDX_W-1:0] mv_src;
  logic [IDX_W-1:0] dpos;
  logic             dir_up;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

  assign scan_go = (state == S_SCAN) && (scan_addr < count);
  assign mv_go   = (state == S_MOVE) && (mv_left != '0);

  always_comb begin
    rd_en   = scan_go || mv_go ||
              ((state == S_IDLE) && ctl.start && (cmd_in.operation == OP_READ));
    rd_addr = mv_addr;
    if (state == S_IDLE) begin
      rd_addr = cmd_in.read_index;
    end else if (state == S_SCAN) begin
      rd_addr = scan_addr[IDX_W-1:0];
    end
    wr_en   = ((state == S_MOVE) && pend) || (state == S_WRITE);
    wr_addr = mv_up ? (pend_idx - IDX_W'(1)) : (pend_idx + IDX_W'(1));
    wr_data = rd_data;
    if (state == S_WRITE) begin
      wr_addr       = dst;
      wr_data.id    = cmd.player_id;
      wr_data.score = cmd.total_score;
    end
  end

  assign s_match = pend && (cmd.player_id != '0) && (rd_data.id == cmd.player_id) && !found;
  assign s_gt    = rd_data.score > cmd.total_score;
  assign s_eq    = rd_data.score == cmd.total_score;

  always_comb begin
    if (found) begin
      mv_src = fidx;
    end else if (count < CNT_W'(RANK_SIZE)) begin
      mv_src = count[IDX_W-1:0];
    end else begin
      mv_src = IDX_W'(RANK_SIZE - 1);
    end
    dpos   = pos[IDX_W-1:0];
    dir_up = dpos > mv_src;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      count <= '0;
      pend  <= 1'b0;
      found <= 1'b0;
      mv_up <= 1'b0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (ctl.start) begin
            cmd       <= cmd_in;
            scan_addr <= '0;
            pend      <= 1'b0;
            found     <= 1'b0;
            pos       <= '0;
            res_r     <= '0;
            unique case (cmd_in.operation)
              OP_UPDATE: state <= S_SCAN;
              OP_READ:   state <= S_READ;
              OP_CLEAR: begin
                count <= '0;
                state <= S_DONE;
              end
              default:   state <= S_DONE;
            endcase
          end
        end
        S_SCAN: begin
          if (scan_go) begin
            scan_addr <= scan_addr + CNT_W'(1);
            pend      <= 1'b1;
            pend_idx  <= scan_addr[IDX_W-1:0];
          end else begin
            pend <= 1'b0;
          end
          if (pend) begin
            if (s_match) begin
              found  <= 1'b1;
              fidx   <= pend_idx;
              fscore <= rd_data.score;
            end else if (s_gt || (s_eq && !found)) begin
              pos <= pos + CNT_W'(1);
            end
            if (pend_idx == IDX_W'(RANK_SIZE - 1)) begin
              lscore <= rd_data.score;
            end
          end
          if (!scan_go && !pend) begin
            state <= S_DECIDE;
          end
        end
        S_DECIDE: begin
          priority if (cmd.score_delta == '0) begin
            res_r.ranked        <= found;
            res_r.rank_position <= found ? fidx : '0;
            res_r.entry_id      <= found ? cmd.player_id : '0;
            res_r.entry_score   <= found ? fscore : '0;
            state               <= S_DONE;
          end else if (found || (count < CNT_W'(RANK_SIZE)) || (cmd.total_score > lscore)) begin
            if (!found && (count < CNT_W'(RANK_SIZE))) begin
              count <= count + CNT_W'(1);
            end
            dst                 <= dpos;
            mv_up               <= dir_up;
            mv_addr             <= dir_up ? (mv_src + IDX_W'(1)) : (mv_src - IDX_W'(1));
            mv_left             <= dir_up ? CNT_W'(dpos - mv_src) : CNT_W'(mv_src - dpos);
            res_r.ranked        <= 1'b1;
            res_r.rank_position <= dpos;
            res_r.entry_id      <= cmd.player_id;
            res_r.entry_score   <= cmd.total_score;
            state               <= S_MOVE;
          end else begin
            state <= S_DONE;
          end
        end
        S_MOVE: begin
          if (mv_go) begin
            pend     <= 1'b1;
            pend_idx <= mv_addr;
            mv_addr  <= mv_up ? (mv_addr + IDX_W'(1)) : (mv_addr - IDX_W'(1));
            mv_left  <= mv_left - CNT_W'(1);
          end else begin
            pend <= 1'b0;
          end
          if (!mv_go && !pend) begin
            state <= S_WRITE;
          end
        end
        S_WRITE: begin
          state <= S_DONE;
        end
        S_READ: begin
          res_r.rank_position <= cmd.read_index;
          if (CNT_W'(cmd.read_index) < count) begin
            res_r.ranked      <= 1'b1;
            res_r.entry_id    <= rd_data.id;
            res_r.entry_score <= rd_data.score;
          end
          state <= S_DONE;
        end
        S_DONE: begin
          if (ctl.take) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  always_comb begin
    res             = res_r;
    res.entry_count = count;
  end

  assign sts.idle = (state == S_IDLE);
  assign sts.done = (state == S_DONE);

endmodule

`default_nettype wire

/* src/top_k_score_table_unit.sv */
// Top level of the top-k score table: input handshake, engine and result register.
//
// Keeps up to RANK_SIZE (id, score) entries in descending score order, ties in
// arrival order. Items arrive on item/item_valid/item_stall; a transfer happens
// when item_valid is high and item_stall is low. Operations: update a score,
// read the entry at an index, clear the table. Every item gives exactly one
// result on result/result_valid/result_stall.
// One item is worked at a time. An update scans the occupied entries out of the
// table memory one per cycle; if a non-zero delta places the entry, it then
// shifts the entries between the old and the new position one per cycle and
// writes the entry. A read fetches the entry at its index; a clear or an
// unused code touches no entry. The next item is taken in the cycle after the
// engine hands its result over.
// The result register holds a finished result while result_stall is high; the
// next item is taken meanwhile, and its own result waits in the engine.
// Reset empties the table at once (the count is cleared; stale entries are
// never reported) and drops any pending result.
`default_nettype none

module top_k_score_table_unit import tkst_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    item_valid,
  output logic    item_stall,
  input  item_t   item,
  output logic    result_valid,
  input  logic    result_stall,
  output result_t result
);

  eng_ctl_t ctl;
  eng_sts_t sts;
  result_t  eng_res;

  assign item_stall = !sts.idle;
  assign ctl.start  = item_valid && sts.idle;
  assign ctl.take   = sts.done && (!result_valid || !result_stall);

  tkst_engine u_engine (
    .clk    (clk),
    .rst    (rst),
    .ctl    (ctl),
    .cmd_in (item),
    .sts    (sts),
    .res    (eng_res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (ctl.take) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.take) begin
      result <= eng_res;
    end
  end

  a_busy_after_transfer: assert property (@(posedge clk) disable iff (rst)
    item_valid && !item_stall |=> item_stall)
    else $error("input transfer did not start the engine");

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> result.entry_count <= CNT_W'(RANK_SIZE))
    else $error("entry count beyond table size");

  a_unranked_empty: assert property (@(posedge clk) disable iff (rst)
    result_valid && !result.ranked |-> result.entry_id == '0 && result.entry_score == '0)
    else $error("unranked result carries an entry");

  a_rank_in_table: assert property (@(posedge clk) disable iff (rst)
    result_valid && result.ranked |-> CNT_W'(result.rank_position) < result.entry_count)
    else $error("ranked position outside occupied entries");

endmodule

`default_nettype wire

/* tb/tkst_checker.sv */
// Checker for the top-k score table: watches both channels, predicts each result and compares.
`timescale 1ns / 100ps

module tkst_checker import tkst_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    item_valid,
  input  logic    item_stall,
  input  item_t   item,
  input  logic    result_valid,
  input  logic    result_stall,
  input  result_t result,
  output int      fail_count,
  output int      pending,
  output int      checked
);

  entry_t  board [RANK_SIZE];
  int      filled = 0;
  result_t predicted_results [$];
  int      errors = 0;
  int      n_checked = 0;

  task automatic report_mismatch(input string field, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("%0t mismatch on %s: got %0h, want %0h", $realtime, field, got, want);
    errors++;
  endtask

  function automatic int lookup_id(input logic [ID_W-1:0] id);
    if (id == '0) return -1;
    for (int i = 0; i < filled; i++)
      if (board[i].id == id) return i;
    return -1;
  endfunction

  // stable insertion sort by descending score; follow one entry through it
  function automatic int reorder(input int tracked);
    entry_t moving;
    int     j;
    for (int i = 1; i < filled; i++) begin
      moving = board[i];
      j = i;
      while (j > 0 && board[j-1].score < moving.score) begin
        board[j] = board[j-1];
        j--;
      end
      board[j] = moving;
      if (tracked == i) tracked = j;
      else if (tracked >= j && tracked < i) tracked++;
    end
    return tracked;
  endfunction

  function automatic result_t rank_outcome(input item_t it);
    result_t r;
    int      found;
    int      where;
    r = '0;
    where = -1;
    case (it.operation)
      OP_UPDATE: begin
        found = lookup_id(it.player_id);
        if (it.score_delta == 0) begin
          where = found;
        end else if (found >= 0) begin
          board[found].score = it.total_score;
          where = reorder(found);
        end else if (filled < RANK_SIZE) begin
          board[filled].id    = it.player_id;
          board[filled].score = it.total_score;
          filled++;
          where = reorder(filled - 1);
        end else if (it.total_score > board[RANK_SIZE-1].score) begin
          board[RANK_SIZE-1].id    = it.player_id;
          board[RANK_SIZE-1].score = it.total_score;
          where = reorder(RANK_SIZE - 1);
        end
        if (where >= 0) begin
          r.ranked        = 1'b1;
          r.rank_position = where[IDX_W-1:0];
          r.entry_id      = board[where].id;
          r.entry_score   = board[where].score;
        end
      end
      OP_READ: begin
        r.rank_position = it.read_index;
        if (it.read_index < filled) begin
          r.ranked      = 1'b1;
          r.entry_id    = board[it.read_index].id;
          r.entry_score = board[it.read_index].score;
        end
      end
      OP_CLEAR: begin
        for (int i = 0; i < RANK_SIZE; i++) board[i] = '0;
        filled = 0;
      end
      default: ;
    endcase
    r.entry_count = filled[CNT_W-1:0];
    return r;
  endfunction

  always @(posedge clk) begin : watch
    result_t want;
    if (rst) begin
      for (int i = 0; i < RANK_SIZE; i++) board[i] = '0;
      filled = 0;
      predicted_results.delete();
    end else begin
      if (result_valid && !result_stall) begin
        if (predicted_results.size() == 0) begin
          report_mismatch("unexpected result entry_id", result.entry_id, '0);
        end else begin
          want = predicted_results.pop_front();
          if (result.ranked !== want.ranked)
            report_mismatch("ranked", result.ranked, want.ranked);
          if (result.rank_position !== want.rank_position)
            report_mismatch("rank_position", result.rank_position, want.rank_position);
          if (result.entry_id !== want.entry_id)
            report_mismatch("entry_id", result.entry_id, want.entry_id);
          if (result.entry_score !== want.entry_score)
            report_mismatch("entry_score", result.entry_score, want.entry_score);
          if (result.entry_count !== want.entry_count)
            report_mismatch("entry_count", result.entry_count, want.entry_count);
          n_checked++;
        end
      end
      if (item_valid && !item_stall)
        predicted_results.push_back(rank_outcome(item));
    end
    fail_count <= errors;
    pending    <= predicted_results.size();
    checked    <= n_checked;
  end

endmodule

/* tb/testbench.sv */
// Top of the top-k score table testbench: clock, reset, stimulus, receiver stalls and verdict.
`timescale 1ns / 100ps

module testbench;
  import tkst_pkg::*;

  localparam logic [1:0] OP_UNUSED   = 2'd3;
  localparam int         RANDOM_ITEMS = 1525;
  localparam int         CYCLE_LIMIT  = 1000000;
  localparam int         HOLD_CYCLES  = 400;

  logic    clk = 1'b0;
  logic    rst = 1'b1;
  logic    item_valid = 1'b0;
  logic    item_stall;
  item_t   item = '0;
  logic    result_valid;
  logic    result_stall = 1'b0;
  result_t result;

  int mismatches;
  int outstanding;
  int compared;

  int sent = 0;
  int n_update = 0;
  int n_read = 0;
  int n_clear = 0;
  int n_unused = 0;
  int burst_left = 0;
  int cycles = 0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  top_k_score_table_unit u_dut (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_stall   (item_stall),
    .item         (item),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result)
  );

  tkst_checker u_checker (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_stall   (item_stall),
    .item         (item),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result),
    .fail_count   (mismatches),
    .pending      (outstanding),
    .checked      (compared)
  );

  function automatic item_t compose_item(input logic [1:0] op, input logic [ID_W-1:0] id,
                                         input logic signed [SCORE_W-1:0] total,
                                         input logic signed [SCORE_W-1:0] delta,
                                         input logic [IDX_W-1:0] idx);
    item_t it;
    it.operation   = op;
    it.player_id   = id;
    it.total_score = total;
    it.score_delta = delta;
    it.read_index  = idx;
    return it;
  endfunction

  function automatic logic [ID_W-1:0] pick_id();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 5) return '0;
    if (r < 70) return ID_W'($urandom_range(1, 20));
    if (r < 80) return 31'h7FFF_FFE0 | ID_W'($urandom_range(0, 15));
    return ID_W'($urandom());
  endfunction

  function automatic logic signed [SCORE_W-1:0] pick_score();
    int unsigned r;
    r = $urandom_range(0, 9);
    if (r < 4) return SCORE_W'(int'($urandom_range(0, 16)) - 8);
    if (r < 6) begin
      case ($urandom_range(0, 5))
        0:       return 32'sh7FFF_FFFF;
        1:       return 32'sh8000_0000;
        2:       return 32'sh7FFF_FFFE;
        3:       return 32'sh8000_0001;
        4:       return 32'sh0;
        default: return -32'sd1;
      endcase
    end
    return SCORE_W'($urandom());
  endfunction

  function automatic logic signed [SCORE_W-1:0] pick_delta();
    int unsigned r;
    r = $urandom_range(0, 9);
    if (r == 0) return '0;
    if (r < 5) return $urandom_range(0, 1) ? SCORE_W'($urandom_range(1, 100))
                                            : -SCORE_W'($urandom_range(1, 100));
    return SCORE_W'($urandom());
  endfunction

  function automatic item_t random_item();
    int unsigned r;
    logic [1:0]  op;
    r = $urandom_range(0, 199);
    if (r < 130) op = OP_UPDATE;
    else if (r < 190) op = OP_READ;
    else if (r < 193) op = OP_CLEAR;
    else op = OP_UNUSED;
    return compose_item(op, pick_id(), pick_score(), pick_delta(),
                        IDX_W'($urandom_range(0, RANK_SIZE - 1)));
  endfunction

  // hold the item until transfer, then pause between bursts
  task automatic offer_item(input item_t it);
    int gap;
    item       <= it;
    item_valid <= 1'b1;
    do @(posedge clk); while (item_stall);
    sent++;
    case (it.operation)
      OP_UPDATE: n_update++;
      OP_READ:   n_read++;
      OP_CLEAR:  n_clear++;
      default:   n_unused++;
    endcase
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      if (gap > 0) begin
        item_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 30);
    end
  endtask

  initial begin : receiver
    int  mode;
    int  seg;
    bit  held;
    held = 1'b0;
    forever begin
      mode = $urandom_range(0, 3);
      seg  = $urandom_range(10, 150);
      repeat (seg) begin
        @(posedge clk);
        if (!held && sent >= 500) begin
          result_stall <= 1'b1;
          repeat (HOLD_CYCLES) @(posedge clk);
          held = 1'b1;
        end
        case (mode)
          0:       result_stall <= 1'b0;
          1:       result_stall <= 1'($urandom_range(0, 1));
          2:       result_stall <= ($urandom_range(0, 3) != 0);
          default: result_stall <= ~result_stall;
        endcase
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles == CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles with %0d results outstanding", cycles, outstanding);
      $display("Regression FAIL");
      $finish;
    end
  end

  initial begin : stimulus
    int drain;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    offer_item(compose_item(OP_READ, '0, '0, '0, 4'd0));
    offer_item(compose_item(OP_UPDATE, 31'd5, 32'sd9, '0, 4'd3));
    offer_item(compose_item(OP_UPDATE, '0, 32'sd7, 32'sd1, 4'd0));
    offer_item(compose_item(OP_UPDATE, '0, 32'sd7, 32'sd1, 4'd0));
    offer_item(compose_item(OP_UPDATE, 31'h7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 4'd0));
    offer_item(compose_item(OP_UPDATE, 31'd1, 32'sh8000_0000, 32'sh8000_0000, 4'd0));
    offer_item(compose_item(OP_UPDATE, 31'd2, -32'sd1, -32'sd1, 4'd0));
    offer_item(compose_item(OP_UPDATE, 31'd3, 32'sd7, 32'sd3, 4'd0));
    offer_item(compose_item(OP_UPDATE, 31'd1, 32'sd7, 32'sd1, 4'd0));
    offer_item(compose_item(OP_UPDATE, 31'd3, 32'sd123, '0, 4'd0));
    for (int k = 0; k < 10; k++)
      offer_item(compose_item(OP_UPDATE, ID_W'(100 + k), SCORE_W'(-100 - k), -32'sd5, 4'd0));
    offer_item(compose_item(OP_UPDATE, 31'd50, -32'sd109, 32'sd1, 4'd0));
    offer_item(compose_item(OP_UPDATE, 31'd51, -32'sd108, 32'sd1, 4'd0));
    offer_item(compose_item(OP_READ, '0, '0, '0, 4'd15));
    offer_item(compose_item(OP_UNUSED, 31'h7FFF_FFFF, -32'sd1, -32'sd1, 4'd15));
    offer_item(compose_item(OP_CLEAR, 31'd3, 32'sd5, 32'sd5, 4'd2));
    offer_item(compose_item(OP_READ, '0, '0, '0, 4'd0));

    for (int n = 0; n < RANDOM_ITEMS; n++)
      offer_item(random_item());
    item_valid <= 1'b0;

    drain = 0;
    do begin
      @(posedge clk);
      drain++;
    end while (outstanding != 0 && drain < 20000);
    repeat (80) @(posedge clk);

    $display("Covered %0d items: %0d updates, %0d reads, %0d clears, %0d unused codes",
             sent, n_update, n_read, n_clear, n_unused);
    $display("%0d results compared, %0d mismatches, %0d left unanswered",
             compared, mismatches, outstanding);
    if (mismatches == 0 && outstanding == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

/* filelist.f */
src/tkst_pkg.sv
src/tkst_engine.sv
src/top_k_score_table_unit.sv
tb/tkst_checker.sv
tb/testbench.sv
